[src/wsft_pkg.sv]
// Shared constants and types for the working-set fault tracker.
// No dependencies; used by the top level and the bench.
package wsft_pkg;

  // Page space and window depth
  localparam int NUM_PAGES  = 256;
  localparam int MAX_WINDOW = 256;
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int HIST_AW    = $clog2(MAX_WINDOW);

  // Fill, distinct count and per-page counts span 0..256; the window size register spans 0..511
  localparam int WIN_W = 9;
  localparam int CNT_W = 9;

  // Running totals
  localparam int FAULT_W = 32;
  localparam int SIZE_W  = 40;
  localparam int REF_W   = 32;

  // Register file
  localparam int  CFG_AW = 3;
  localparam int  CFG_DW = 32;
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 9'd200;

  // Second pipeline stage: result of the count update, pending eviction write
  typedef struct packed {
    logic              fault;
    logic [WIN_W-1:0]  ws_size;
    logic              old_wr;
    logic [PAGE_W-1:0] old_page;
    logic [CNT_W-1:0]  old_cnt;
  } s2_t;

endpackage

[src/wsft_ram.sv]
// Generic synchronous RAM: one write port, two registered read ports.
// Read-first on an address collision. No package dependency.
module wsft_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [W-1:0]             rdata_a,
  output logic [W-1:0]             rdata_b
);

  logic [W-1:0] mem [DEPTH];

  // Write and read in one process so a same-address read returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[src/working_set_fault_tracker.sv]
// Working-set page fault tracker: top level with count update pipeline.
// Depends on wsft_pkg and wsft_ram.
//
// Usage:
//   in_valid/in_ready carries one page reference per request (in_page_number).
//   out_valid/out_ready returns one result per request: fault flag, size of
//   the working set ending at that reference and saturating running totals.
//   APB port (psel..pready, pready always high) holds window_size at byte 0;
//   writing it empties the window and keeps the totals. Write only while idle.
// Pipeline: an accepted request passes through stage 1, stage 2 and the
//   output register before its result is valid. A new request is not taken
//   while the previous one is in stage 1: each reference reads two entries
//   of the occurrence count RAM and writes both back through its single
//   write port (incoming page, then evicted page). The evicted page is
//   prefetched from the history RAM in the cycle after each request.
// Reset: window_size returns to 200, window and totals are cleared. Count RAM
//   entries are qualified by flip-flop valid bits, so no clearing pass.
// Stall: a held result keeps its output register; one further request may be
//   worked up to the last stage, then in_ready drops until out_ready returns.
module working_set_fault_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  // reference requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wsft_pkg::PAGE_W-1:0]   in_page_number,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_page_fault,
  output logic [wsft_pkg::WIN_W-1:0]    out_working_set_size,
  output logic [wsft_pkg::FAULT_W-1:0]  out_total_faults,
  output logic [wsft_pkg::SIZE_W-1:0]   out_total_size_sum,
  output logic [wsft_pkg::REF_W-1:0]    out_references_seen,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wsft_pkg::CFG_AW-1:0]   paddr,
  input  logic [wsft_pkg::CFG_DW-1:0]   pwdata,
  output logic [wsft_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int PAGE_W  = wsft_pkg::PAGE_W;
  localparam int HIST_AW = wsft_pkg::HIST_AW;
  localparam int WIN_W   = wsft_pkg::WIN_W;
  localparam int CNT_W   = wsft_pkg::CNT_W;
  localparam int SIZE_W  = wsft_pkg::SIZE_W;
  localparam int SUM_W   = SIZE_W + 1;

  // Configuration and window state
  logic [WIN_W-1:0]              win_r, win_nxt;
  logic [HIST_AW-1:0]            ptr_r, ptr_nxt;
  logic [WIN_W-1:0]              fill_r, fill_nxt;
  logic [WIN_W-1:0]              distinct_r, distinct_nxt;
  logic [wsft_pkg::NUM_PAGES-1:0] valid_r, valid_nxt;

  // Stage 1: count RAM data returning
  logic                          s1_vld_r;
  logic [PAGE_W-1:0]             s1_page_r;
  logic [PAGE_W-1:0]             s1_old_r;
  logic                          s1_evict_r;
  logic                          s1_vnew_r;
  logic                          s1_vold_r;

  // Stage 2: totals and eviction write-back
  logic                          s2_vld_r, s2_vld_nxt;
  wsft_pkg::s2_t                 s2_r, s2_nxt;

  // Write forwarding into a read issued at the same edge
  logic                          fwd_vld_r;
  logic [PAGE_W-1:0]             fwd_addr_r;
  logic [CNT_W-1:0]              fwd_data_r;

  // Totals and output register
  logic [wsft_pkg::FAULT_W-1:0]  faults_r, faults_nxt;
  logic [SIZE_W-1:0]             size_r, size_nxt;
  logic [wsft_pkg::REF_W-1:0]    refs_r, refs_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_fault_r;
  logic [WIN_W-1:0]              out_ws_r;

  // RAM ports
  logic                          cnt_we;
  logic [PAGE_W-1:0]             cnt_waddr;
  logic [CNT_W-1:0]              cnt_wdata;
  logic [CNT_W-1:0]              cnt_rd_new, cnt_rd_old;
  logic [PAGE_W-1:0]             hist_old;
  logic [HIST_AW-1:0]            hist_raddr;

  logic                          cfg_wr;
  logic [WIN_W-1:0]              eff_w;
  logic                          evict_now;
  logic                          accept;
  logic                          s2_go;
  logic [CNT_W-1:0]              cnt_new, cnt_old, cnt_dec, cnt_base;
  logic                          same_page, lost;
  logic [WIN_W-1:0]              distinct_dec;
  logic [SUM_W-1:0]              size_sum;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == wsft_pkg::REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == wsft_pkg::REG_WINDOW_SIZE) ?
                  wsft_pkg::CFG_DW'(win_r) : '0;

  // Effective window length, clamped to 1..MAX_WINDOW
  always_comb begin
    if (win_r == '0) begin
      eff_w = WIN_W'(1);
    end else if (win_r > WIN_W'(wsft_pkg::MAX_WINDOW)) begin
      eff_w = WIN_W'(wsft_pkg::MAX_WINDOW);
    end else begin
      eff_w = win_r;
    end
  end

  assign evict_now = (fill_r >= eff_w);

  // Handshake; no request is taken while reset is held
  assign s2_go    = s2_vld_r && (!out_valid_r || out_ready);
  assign in_ready = rst_n && !s1_vld_r && (!s2_vld_r || s2_go);
  assign accept   = in_valid && in_ready;

  // History ring: written at accept, next victim prefetched in stage 1
  assign hist_raddr = ptr_r - fill_r[HIST_AW-1:0];

  wsft_ram #(
    .W     (PAGE_W),
    .DEPTH (wsft_pkg::MAX_WINDOW)
  ) u_hist_ram (
    .clk     (clk),
    .we      (accept),
    .waddr   (ptr_r),
    .wdata   (in_page_number),
    .re      (s1_vld_r),
    .raddr_a (hist_raddr),
    .raddr_b (hist_raddr),
    .rdata_a (hist_old),
    .rdata_b ()
  );

  // Occurrence counts: read incoming and evicted page together
  wsft_ram #(
    .W     (CNT_W),
    .DEPTH (wsft_pkg::NUM_PAGES)
  ) u_cnt_ram (
    .clk     (clk),
    .we      (cnt_we),
    .waddr   (cnt_waddr),
    .wdata   (cnt_wdata),
    .re      (accept),
    .raddr_a (in_page_number),
    .raddr_b (hist_old),
    .rdata_a (cnt_rd_new),
    .rdata_b (cnt_rd_old)
  );

  // Stage 1: qualify with valid bits, apply forwarding, update counts
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == s1_page_r)) begin
      cnt_new = fwd_data_r;
    end else begin
      cnt_new = s1_vnew_r ? cnt_rd_new : '0;
    end
    if (fwd_vld_r && (fwd_addr_r == s1_old_r)) begin
      cnt_old = fwd_data_r;
    end else begin
      cnt_old = s1_vold_r ? cnt_rd_old : '0;
    end
    same_page    = s1_evict_r && (s1_old_r == s1_page_r);
    cnt_dec      = (cnt_old != '0) ? cnt_old - CNT_W'(1) : '0;
    lost         = s1_evict_r && (cnt_old == CNT_W'(1)) && (distinct_r != '0);
    distinct_dec = lost ? distinct_r - WIN_W'(1) : distinct_r;
    // same page leaving and entering: count goes through the decrement
    cnt_base     = same_page ? cnt_dec : cnt_new;
  end

  // Count RAM write port: incoming page in stage 1, evicted page in stage 2
  always_comb begin
    if (s1_vld_r) begin
      cnt_we    = 1'b1;
      cnt_waddr = s1_page_r;
      cnt_wdata = cnt_base + CNT_W'(1);
    end else begin
      cnt_we    = s2_go && s2_r.old_wr;
      cnt_waddr = s2_r.old_page;
      cnt_wdata = s2_r.old_cnt;
    end
  end

  // Window state next values
  always_comb begin
    win_nxt      = win_r;
    ptr_nxt      = ptr_r;
    fill_nxt     = fill_r;
    distinct_nxt = distinct_r;
    valid_nxt    = valid_r;
    if (cfg_wr) begin
      win_nxt      = pwdata[WIN_W-1:0];
      ptr_nxt      = '0;
      fill_nxt     = '0;
      distinct_nxt = '0;
      valid_nxt    = '0;
    end else begin
      if (accept) begin
        ptr_nxt = ptr_r + HIST_AW'(1);
        if (!evict_now) begin
          fill_nxt = fill_r + WIN_W'(1);
        end
      end
      if (s1_vld_r) begin
        distinct_nxt = (cnt_base == '0) ? distinct_dec + WIN_W'(1) : distinct_dec;
      end
      if (cnt_we) begin
        valid_nxt[cnt_waddr] = 1'b1;
      end
    end
  end

  // Stage 2 next values
  always_comb begin
    s2_nxt = s2_r;
    if (s1_vld_r) begin
      s2_vld_nxt      = 1'b1;
      s2_nxt.fault    = (cnt_new == '0);
      s2_nxt.ws_size  = (cnt_base == '0) ? distinct_dec + WIN_W'(1) : distinct_dec;
      s2_nxt.old_wr   = s1_evict_r && !same_page;
      s2_nxt.old_page = s1_old_r;
      s2_nxt.old_cnt  = cnt_dec;
    end else begin
      s2_vld_nxt = s2_vld_r && !s2_go;
    end
  end

  // Saturating totals
  assign size_sum = {1'b0, size_r} + SUM_W'(s2_r.ws_size);

  always_comb begin
    faults_nxt = faults_r;
    size_nxt   = size_r;
    refs_nxt   = refs_r;
    if (s2_go) begin
      if (s2_r.fault && (faults_r != '1)) begin
        faults_nxt = faults_r + 1'b1;
      end
      size_nxt = size_sum[SIZE_W] ? '1 : size_sum[SIZE_W-1:0];
      if (refs_r != '1) begin
        refs_nxt = refs_r + 1'b1;
      end
    end
  end

  // Output register
  always_comb begin
    if (s2_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= wsft_pkg::WINDOW_RESET;
      ptr_r       <= '0;
      fill_r      <= '0;
      distinct_r  <= '0;
      valid_r     <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      fwd_vld_r   <= 1'b0;
      faults_r    <= '0;
      size_r      <= '0;
      refs_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      distinct_r  <= distinct_nxt;
      valid_r     <= valid_nxt;
      s1_vld_r    <= accept;
      s2_vld_r    <= s2_vld_nxt;
      fwd_vld_r   <= cnt_we;
      faults_r    <= faults_nxt;
      size_r      <= size_nxt;
      refs_r      <= refs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_page_r  <= in_page_number;
      s1_old_r   <= hist_old;
      s1_evict_r <= evict_now;
      s1_vnew_r  <= valid_r[in_page_number];
      s1_vold_r  <= valid_r[hist_old];
    end
    s2_r       <= s2_nxt;
    fwd_addr_r <= cnt_waddr;
    fwd_data_r <= cnt_wdata;
    if (s2_go) begin
      out_fault_r <= s2_r.fault;
      out_ws_r    <= s2_r.ws_size;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_page_fault       = out_fault_r;
  assign out_working_set_size = out_ws_r;
  assign out_total_faults     = faults_r;
  assign out_total_size_sum   = size_r;
  assign out_references_seen  = refs_r;

endmodule

[bench/tb.sv]
// Self-checking bench for working_set_fault_tracker: page references in, one result each.
// Depends on wsft_pkg and the block's RTL; a scoreboard class predicts and checks results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // package constants used by the bench
  localparam int NUM_PAGES  = wsft_pkg::NUM_PAGES;
  localparam int MAX_WINDOW = wsft_pkg::MAX_WINDOW;
  localparam int PAGE_W     = wsft_pkg::PAGE_W;
  localparam int WIN_W      = wsft_pkg::WIN_W;
  localparam int FAULT_W    = wsft_pkg::FAULT_W;
  localparam int SIZE_W     = wsft_pkg::SIZE_W;
  localparam int REF_W      = wsft_pkg::REF_W;
  localparam int CFG_AW     = wsft_pkg::CFG_AW;
  localparam int CFG_DW     = wsft_pkg::CFG_DW;
  localparam logic REG_WINDOW_SIZE = wsft_pkg::REG_WINDOW_SIZE;
  localparam logic [WIN_W-1:0] WINDOW_RESET = wsft_pkg::WINDOW_RESET;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = 6;
  localparam int LONG_HOLD    = 80;
  localparam int RANDOM_REFS  = 1900;
  localparam int CALM_AFTER   = 1650;

  // byte addresses on the config port
  localparam logic [CFG_AW-1:0] WINDOW_ADDR = CFG_AW'(4 * REG_WINDOW_SIZE);
  localparam logic [CFG_AW-1:0] SPARE_ADDR  = CFG_AW'(4 * (REG_WINDOW_SIZE + 1));

  typedef struct packed {
    logic               fault;
    logic [WIN_W-1:0]   ws_size;
    logic [FAULT_W-1:0] faults;
    logic [SIZE_W-1:0]  size_sum;
    logic [REF_W-1:0]   refs;
  } ws_result_t;

  // Working-set predictor plus in-order result check
  class fault_scoreboard;
    logic [WIN_W-1:0]   window_reg;
    logic [PAGE_W-1:0]  history [MAX_WINDOW];
    int unsigned        occurrences [NUM_PAGES];
    int unsigned        distinct, fill, head;
    logic [FAULT_W-1:0] fault_total;
    logic [SIZE_W-1:0]  size_total;
    logic [REF_W-1:0]   ref_total;
    ws_result_t         expected_q [$];
    int unsigned        errors, checked, faults_seen;

    function new();
      window_reg  = WINDOW_RESET;
      fault_total = '0;
      size_total  = '0;
      ref_total   = '0;
      errors      = 0;
      checked     = 0;
      faults_seen = 0;
      foreach (history[i]) history[i] = '0;
      empty_window();
    endfunction

    function void empty_window();
      foreach (occurrences[i]) occurrences[i] = 0;
      distinct = 0;
      fill     = 0;
      head     = 0;
    endfunction

    // only the window register exists; other indexes are ignored
    function void write_register(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
      if ((addr >> 2) == REG_WINDOW_SIZE) begin
        window_reg = value[WIN_W-1:0];
        empty_window();
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [PAGE_W-1:0] page);
      int unsigned win, oldest;
      logic [SIZE_W:0] sum;
      ws_result_t r;
      win = (window_reg == 0) ? 1 : ((window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg);
      r.fault = (occurrences[page] == 0);
      // evict oldest reference once the window is full
      if (fill >= win) begin
        oldest = (head + MAX_WINDOW - fill) % MAX_WINDOW;
        if (occurrences[history[oldest]] > 0) begin
          occurrences[history[oldest]]--;
          if (occurrences[history[oldest]] == 0 && distinct > 0) distinct--;
        end
        fill--;
      end
      history[head] = page;
      head = (head + 1) % MAX_WINDOW;
      if (occurrences[page] == 0) distinct++;
      occurrences[page]++;
      fill++;
      // saturating totals
      if (r.fault && fault_total != '1) fault_total++;
      sum = size_total + distinct;
      size_total = sum[SIZE_W] ? '1 : sum[SIZE_W-1:0];
      if (ref_total != '1) ref_total++;
      r.ws_size  = WIN_W'(distinct);
      r.faults   = fault_total;
      r.size_sum = size_total;
      r.refs     = ref_total;
      expected_q.push_back(r);
    endfunction

    function void check_result(ws_result_t got);
      ws_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.fault) faults_seen++;
      if (got.fault !== want.fault) begin
        $error("page_fault: expected %0d, got %0d", want.fault, got.fault);
        errors++;
      end
      if (got.ws_size !== want.ws_size) begin
        $error("working_set_size: expected %0d, got %0d", want.ws_size, got.ws_size);
        errors++;
      end
      if (got.faults !== want.faults) begin
        $error("total_faults: expected %0d, got %0d", want.faults, got.faults);
        errors++;
      end
      if (got.size_sum !== want.size_sum) begin
        $error("total_size_sum: expected %0d, got %0d", want.size_sum, got.size_sum);
        errors++;
      end
      if (got.refs !== want.refs) begin
        $error("references_seen: expected %0d, got %0d", want.refs, got.refs);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [PAGE_W-1:0]   in_page_number = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_page_fault;
  logic [WIN_W-1:0]    out_working_set_size;
  logic [FAULT_W-1:0]  out_total_faults;
  logic [SIZE_W-1:0]   out_total_size_sum;
  logic [REF_W-1:0]    out_references_seen;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  bit                  calm = 1'b0;
  int unsigned         hold_asks = 0;
  int unsigned         cycles = 0;
  fault_scoreboard     sb = new();

  working_set_fault_tracker dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_page_number       (in_page_number),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_page_fault       (out_page_fault),
    .out_working_set_size (out_working_set_size),
    .out_total_faults     (out_total_faults),
    .out_total_size_sum   (out_total_size_sum),
    .out_references_seen  (out_references_seen),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // handshake monitor: requests feed the predictor, results are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_page_number);
      if (out_valid && out_ready)
        sb.check_result('{out_page_fault, out_working_set_size, out_total_faults,
                          out_total_size_sum, out_references_seen});
    end
  end

  // result sink: random stalls, quiet stretches, and long holds on request
  initial begin : result_sink
    int unsigned stall_left, quiet_left, hold_done;
    stall_left = 0;
    quiet_left = 0;
    hold_done  = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_done) begin
        hold_done++;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && quiet_left == 0 && !calm) begin
        if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(50, 200);
        else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 13);
      end
      if (quiet_left > 0) quiet_left--;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // hold one reference until accepted
  task automatic send_page(input logic [PAGE_W-1:0] page);
    in_valid       <= 1'b1;
    in_page_number <= page;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic feed(input logic [PAGE_W-1:0] page, input bit may_idle);
    send_page(page);
    if (may_idle && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // two-phase register write; block must be idle
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_register(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [PAGE_W-1:0] opening [] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'h80, 8'h7F};
    logic [PAGE_W-1:0] base;
    logic [WIN_W-1:0]  win;
    int unsigned       sent, phase, len, span, no_gap_left, settings;
    bit                quiet_phase;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset window, first reference faults, extreme pages
    foreach (opening[i]) feed(opening[i], 1'b0);
    drain();

    // window of one: repeats hit, changes fault
    cfg_write(WINDOW_ADDR, 32'd1);
    feed(8'd5, 1'b0); feed(8'd5, 1'b0); feed(8'd6, 1'b0); feed(8'd5, 1'b0);
    drain();

    // zero in the low bits (upper bit set) acts as a window of one
    cfg_write(WINDOW_ADDR, 32'h0000_0200);
    feed(8'd7, 1'b0); feed(8'd7, 1'b0); feed(8'd8, 1'b0);
    drain();

    cfg_write(WINDOW_ADDR, 32'd2);
    feed(8'd1, 1'b0); feed(8'd2, 1'b0); feed(8'd1, 1'b0); feed(8'd3, 1'b0); feed(8'd1, 1'b0);
    drain();

    // write past the register list must not empty the window
    cfg_write(SPARE_ADDR, 32'hFFFF_FFFF);
    feed(8'd1, 1'b0); feed(8'd3, 1'b0);
    drain();

    // oversize window clamps to the maximum
    cfg_write(WINDOW_ADDR, 32'h0000_01FF);
    feed(8'd1, 1'b0); feed(8'd200, 1'b0);
    drain();
    settings = 5;

    // random phases: new window each phase, pages with tunable locality
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_REFS) begin
      case ($urandom_range(0, 9))
        0:       win = WIN_W'(1);
        1:       win = WIN_W'(MAX_WINDOW);
        2:       win = WIN_W'($urandom_range(MAX_WINDOW + 1, 511));
        3:       win = '0;
        4, 5:    win = WIN_W'($urandom_range(2, MAX_WINDOW - 1));
        default: win = WIN_W'($urandom_range(2, 24));
      endcase
      if ($urandom_range(0, 5) == 0) cfg_write(SPARE_ADDR, $urandom());
      cfg_write(WINDOW_ADDR, ($urandom() & ~32'h1FF) | CFG_DW'(win));
      settings++;

      len = (win >= 128) ? $urandom_range(300, 420) : $urandom_range(20, 120);
      if (phase <= 3 && len < 60) len = 60;
      // keep the total close to the planned request count
      if (len > RANDOM_REFS - sent) len = RANDOM_REFS - sent;
      case ($urandom_range(0, 3))
        0:       span = 3;
        1:       span = 15;
        2:       span = 63;
        default: span = 255;
      endcase
      base        = PAGE_W'($urandom_range(0, 255));
      quiet_phase = ($urandom_range(0, 3) == 0);
      no_gap_left = 0;

      for (int i = 0; i < len; i++) begin
        // back-pressure: long sink hold while references keep coming
        if (phase == 1 && i == 5) begin
          hold_asks   <= hold_asks + 1;
          no_gap_left = 40;
        end
        // sender pause until the block has returned everything
        if (phase == 3 && i == len / 2) drain();
        if (sent >= CALM_AFTER) calm <= 1'b1;
        feed(PAGE_W'(base + $urandom_range(0, span)), !quiet_phase && no_gap_left == 0);
        if (no_gap_left > 0) no_gap_left--;
        sent++;
      end
      drain();
      phase++;
    end

    $display("Checked %0d results (%0d faults) across %0d window settings,",
             sb.checked, sb.faults_seen, settings);
    $display("window lengths from one to full depth, clamped and masked writes, stalls.");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
src/wsft_pkg.sv
src/wsft_ram.sv
src/working_set_fault_tracker.sv
bench/tb.sv
